// File: design/atfp_pkg.sv
`timescale 1ns / 1ps

package atfp_pkg;

  localparam int unsigned MAX_CHARS_DEF = 12;

  localparam int unsigned ID_W   = 8;
  localparam int unsigned MAG_W  = 40;
  localparam int unsigned MANT_W = 41;
  localparam int unsigned FRAC_W = 4;

  localparam logic [7:0] START_BYTE_RST = 8'd36;
  localparam logic [7:0] STOP_BYTE_RST  = 8'd35;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_WAIT_START = 2'd0,
    PH_START_SEEN = 2'd1,
    PH_FIELD      = 2'd2
  } phase_e;

  typedef enum logic {
    CFG_START_BYTE = 1'b0,
    CFG_STOP_BYTE  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [ID_W-1:0]          frame_id;
    logic signed [MANT_W-1:0] mantissa;
    logic [FRAC_W-1:0]        frac_digits;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t data;
  } result_push_t;

endpackage

// File: design/atfp_core.sv
`timescale 1ns / 1ps

module atfp_core #(
  parameter int unsigned MAX_CHARS = atfp_pkg::MAX_CHARS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             rx_byte_i,
  input  logic [7:0]             start_byte_i,
  input  logic [7:0]             stop_byte_i,
  output atfp_pkg::result_push_t result_o
);
  import atfp_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_CHARS + 1);

  phase_e             phase_q, phase_d;
  logic               sign_seen_q, sign_seen_d;
  logic               negative_q, negative_d;
  logic               dot_seen_q, dot_seen_d;
  logic [CNT_W-1:0]   char_count_q, char_count_d;
  logic [ID_W-1:0]    command_id_q, command_id_d;
  logic [MAG_W-1:0]   magnitude_q, magnitude_d;
  logic [FRAC_W-1:0]  frac_count_q, frac_count_d;

  logic               is_sign, is_dot, is_digit, room;
  logic [3:0]         digit;
  logic [MAG_W+3:0]   mag_x10;
  logic [MAG_W-1:0]   mag_next;
  logic [MANT_W-1:0]  mag_ext;
  logic signed [MANT_W-1:0] mantissa;

  assign is_sign  = (rx_byte_i == CHAR_PLUS) || (rx_byte_i == CHAR_MINUS);
  assign is_dot   = (rx_byte_i == CHAR_DOT);
  assign is_digit = (rx_byte_i >= CHAR_ZERO) && (rx_byte_i <= CHAR_NINE);
  assign room     = (char_count_q < CNT_W'(MAX_CHARS));
  assign digit    = rx_byte_i[3:0];

  // times ten as two shifts, saturate on overflow past 40 bits
  assign mag_x10  = ({4'b0, magnitude_q} << 3) + ({4'b0, magnitude_q} << 1)
                  + {{MAG_W{1'b0}}, digit};
  assign mag_next = (|mag_x10[MAG_W+3:MAG_W]) ? {MAG_W{1'b1}} : mag_x10[MAG_W-1:0];

  assign mag_ext  = {1'b0, magnitude_q};
  assign mantissa = negative_q ? -mag_ext : mag_ext;

  always_comb begin
    phase_d      = phase_q;
    sign_seen_d  = sign_seen_q;
    negative_d   = negative_q;
    dot_seen_d   = dot_seen_q;
    char_count_d = char_count_q;
    command_id_d = command_id_q;
    magnitude_d  = magnitude_q;
    frac_count_d = frac_count_q;

    result_o.push             = 1'b0;
    result_o.data.frame_id    = command_id_q;
    result_o.data.mantissa    = mantissa;
    result_o.data.frac_digits = frac_count_q;

    if (step_i) begin
      case (phase_q)
        PH_WAIT_START: begin
          sign_seen_d  = 1'b0;
          negative_d   = 1'b0;
          dot_seen_d   = 1'b0;
          char_count_d = '0;
          magnitude_d  = '0;
          frac_count_d = '0;
          if (rx_byte_i == start_byte_i) begin
            phase_d = PH_START_SEEN;
          end
        end
        PH_START_SEEN: begin
          sign_seen_d  = 1'b0;
          negative_d   = 1'b0;
          dot_seen_d   = 1'b0;
          char_count_d = '0;
          magnitude_d  = '0;
          frac_count_d = '0;
          if (rx_byte_i != start_byte_i) begin
            command_id_d = rx_byte_i;
            phase_d      = PH_FIELD;
          end
        end
        PH_FIELD: begin
          // field characters are checked ahead of start and stop
          if (is_sign) begin
            if (!sign_seen_q && (char_count_q == '0) && room) begin
              char_count_d = char_count_q + CNT_W'(1);
              sign_seen_d  = 1'b1;
              negative_d   = (rx_byte_i == CHAR_MINUS);
            end else begin
              phase_d = PH_WAIT_START;
            end
          end else if (is_dot) begin
            if (!dot_seen_q && room) begin
              char_count_d = char_count_q + CNT_W'(1);
              dot_seen_d   = 1'b1;
            end else begin
              phase_d = PH_WAIT_START;
            end
          end else if (is_digit) begin
            if (room) begin
              char_count_d = char_count_q + CNT_W'(1);
              magnitude_d  = mag_next;
              if (dot_seen_q && (frac_count_q != {FRAC_W{1'b1}})) begin
                frac_count_d = frac_count_q + FRAC_W'(1);
              end
            end else begin
              phase_d = PH_WAIT_START;
            end
          end else if (rx_byte_i == start_byte_i) begin
            sign_seen_d  = 1'b0;
            negative_d   = 1'b0;
            dot_seen_d   = 1'b0;
            char_count_d = '0;
            magnitude_d  = '0;
            frac_count_d = '0;
            phase_d      = PH_START_SEEN;
          end else if (rx_byte_i == stop_byte_i) begin
            result_o.push = 1'b1;
            phase_d       = PH_WAIT_START;
          end else begin
            phase_d = PH_WAIT_START;
          end
        end
        default: begin
          phase_d = PH_WAIT_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_WAIT_START;
      sign_seen_q  <= 1'b0;
      negative_q   <= 1'b0;
      dot_seen_q   <= 1'b0;
      char_count_q <= '0;
      command_id_q <= '0;
      magnitude_q  <= '0;
      frac_count_q <= '0;
    end else begin
      phase_q      <= phase_d;
      sign_seen_q  <= sign_seen_d;
      negative_q   <= negative_d;
      dot_seen_q   <= dot_seen_d;
      char_count_q <= char_count_d;
      command_id_q <= command_id_d;
      magnitude_q  <= magnitude_d;
      frac_count_q <= frac_count_d;
    end
  end

endmodule

// File: design/atfp_out_buf.sv
`timescale 1ns / 1ps

module atfp_out_buf (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  atfp_pkg::result_push_t push_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output atfp_pkg::result_t      data_o
);
  import atfp_pkg::*;

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  assign full_o      = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign data_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i.push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i.push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (!push_i.push && pop) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

endmodule

// File: design/ascii_telecommand_frame_parser.sv
`timescale 1ns / 1ps

// channel   signals                                   direction
// rx        in_valid_i / in_ready_o, rx_byte_i         in
// result    out_valid_o / out_ready_i, frame_id_o,     out
//           mantissa_o, frac_digits_o
// config    cfg_valid_i / cfg_ready_o, cfg_index_i,    in
//           cfg_data_i
//
// one byte per cycle unless rx stalls; a result shows up the cycle after the stop byte transfer
// a two-entry result buffer keeps rx flowing while one result waits
// rx stalls only when both buffer entries hold results not yet taken
// async active-low reset: idle, start byte '$', stop byte '#'
// config is always ready and takes effect on the next byte

module ascii_telecommand_frame_parser #(
  parameter int unsigned MAX_CHARS = atfp_pkg::MAX_CHARS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [7:0]                            rx_byte_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [atfp_pkg::ID_W-1:0]             frame_id_o,
  output logic signed [atfp_pkg::MANT_W-1:0]    mantissa_o,
  output logic [atfp_pkg::FRAC_W-1:0]           frac_digits_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic                                  cfg_index_i,
  input  logic [7:0]                            cfg_data_i
);
  import atfp_pkg::*;

  logic [7:0]   start_byte_q, stop_byte_q;
  logic         buf_full, step;
  result_push_t result;
  result_t      out_data;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !buf_full;
  assign step        = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= START_BYTE_RST;
      stop_byte_q  <= STOP_BYTE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_START_BYTE: start_byte_q <= cfg_data_i;
        CFG_STOP_BYTE:  stop_byte_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  atfp_core #(
    .MAX_CHARS (MAX_CHARS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .rx_byte_i    (rx_byte_i),
    .start_byte_i (start_byte_q),
    .stop_byte_i  (stop_byte_q),
    .result_o     (result)
  );

  atfp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (out_data)
  );

  assign frame_id_o    = out_data.frame_id;
  assign mantissa_o    = out_data.mantissa;
  assign frac_digits_o = out_data.frac_digits;

endmodule

// File: design/atfp_checker.sv
`timescale 1ns / 1ps

module atfp_checker #(
  parameter int unsigned MAX_CHARS = atfp_pkg::MAX_CHARS_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [atfp_pkg::MANT_W-1:0] mantissa_i,
  input logic [atfp_pkg::FRAC_W-1:0]        frac_digits_i
);
  import atfp_pkg::*;

  // nothing comes out of reset
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result valid right after reset");

  // a new result needs a byte transfer the cycle before
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result appeared without a byte transfer");

  // rx only stalls behind a waiting result
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("rx stalled with no result pending");

  // the dot and every fraction digit each cost one character of the length budget
  a_frac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ({28'd0, frac_digits_i} < MAX_CHARS))
    else $error("fraction digit count beyond field limit");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(mantissa_i))
    else $error("result changed while stalled");

endmodule

bind ascii_telecommand_frame_parser atfp_checker #(
  .MAX_CHARS (MAX_CHARS)
) u_atfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_i    (in_ready_o),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .mantissa_i    (mantissa_o),
  .frac_digits_i (frac_digits_o)
);

// File: test/tb.sv
`timescale 1ns / 1ps

import atfp_pkg::*;

// tracks frames the parser should emit and checks them in order
class frame_tracker;
  logic [7:0]  start_byte = START_BYTE_RST;
  logic [7:0]  stop_byte  = STOP_BYTE_RST;
  phase_e      phase = PH_WAIT_START;
  bit          sign_seen;
  bit          negative;
  bit          dot_seen;
  logic [3:0]  char_count;
  logic [7:0]  command_id;
  logic [63:0] magnitude;
  logic [3:0]  fraction_count;
  result_t     expected_frames[$];
  int          errors;
  int          frames_checked;

  function void clear_field();
    sign_seen      = 1'b0;
    negative       = 1'b0;
    dot_seen       = 1'b0;
    char_count     = '0;
    magnitude      = '0;
    fraction_count = '0;
  endfunction

  function void write_register(cfg_reg_e idx, logic [7:0] value);
    if (idx == CFG_START_BYTE) begin
      start_byte = value;
    end else begin
      stop_byte = value;
    end
  endfunction

  // room check for one more stored character, drops the frame when full
  function bit take_char();
    if (int'(char_count) >= int'(MAX_CHARS_DEF)) begin
      phase = PH_WAIT_START;
      return 1'b0;
    end
    char_count = char_count + 4'd1;
    return 1'b1;
  endfunction

  function void parse_byte(logic [7:0] b);
    logic [63:0] d;
    logic [40:0] m;
    result_t     r;
    case (phase)
      PH_WAIT_START: begin
        clear_field();
        if (b == start_byte) phase = PH_START_SEEN;
      end
      PH_START_SEEN: begin
        clear_field();
        if (b != start_byte) begin
          command_id = b;
          phase = PH_FIELD;
        end
      end
      PH_FIELD: begin
        // field characters win over the delimiters
        if (b == CHAR_PLUS || b == CHAR_MINUS) begin
          if (!sign_seen && char_count == 4'd0) begin
            if (take_char()) begin
              sign_seen = 1'b1;
              negative  = (b == CHAR_MINUS);
            end
          end else begin
            phase = PH_WAIT_START;
          end
        end else if (b == CHAR_DOT) begin
          if (dot_seen) begin
            phase = PH_WAIT_START;
          end else if (take_char()) begin
            dot_seen = 1'b1;
          end
        end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
          if (take_char()) begin
            d = {56'd0, b - CHAR_ZERO};
            if (magnitude > (64'h0000_00FF_FFFF_FFFF - d) / 64'd10) begin
              magnitude = 64'h0000_00FF_FFFF_FFFF;
            end else begin
              magnitude = magnitude * 64'd10 + d;
            end
            if (dot_seen && fraction_count < 4'd15) fraction_count = fraction_count + 4'd1;
          end
        end else if (b == start_byte) begin
          clear_field();
          phase = PH_START_SEEN;
        end else if (b == stop_byte) begin
          m = magnitude[40:0];
          if (negative) m = ~m + 41'd1;
          r.frame_id    = command_id;
          r.mantissa    = m;
          r.frac_digits = fraction_count;
          expected_frames.push_back(r);
          phase = PH_WAIT_START;
        end else begin
          phase = PH_WAIT_START;
        end
      end
      default: phase = PH_WAIT_START;
    endcase
  endfunction

  function void check_frame(logic [7:0] id, logic signed [40:0] mant, logic [3:0] frac);
    result_t e;
    if (expected_frames.size() == 0) begin
      $display("%0t: unexpected frame id %0d mantissa %0d frac_digits %0d",
               $time, id, mant, frac);
      errors++;
      return;
    end
    e = expected_frames.pop_front();
    frames_checked++;
    if (id !== e.frame_id) begin
      $display("%0t: frame_id expected %0d actual %0d", $time, e.frame_id, id);
      errors++;
    end
    if (mant !== e.mantissa) begin
      $display("%0t: mantissa expected %0d actual %0d", $time, e.mantissa, mant);
      errors++;
    end
    if (frac !== e.frac_digits) begin
      $display("%0t: frac_digits expected %0d actual %0d", $time, e.frac_digits, frac);
      errors++;
    end
  endfunction

  function int pending();
    return expected_frames.size();
  endfunction
endclass

module tb;

  localparam int PHASES       = 8;
  localparam int PHASE_BYTES  = 140;
  localparam int SETTLE_LIMIT = 2000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [7:0]               rx_byte_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [ID_W-1:0]          frame_id_o;
  logic signed [MANT_W-1:0] mantissa_o;
  logic [FRAC_W-1:0]        frac_digits_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic                     cfg_index_i = 1'b0;
  logic [7:0]               cfg_data_i = '0;

  frame_tracker tracker = new();

  logic [7:0] cur_start = START_BYTE_RST;
  logic [7:0] cur_stop  = STOP_BYTE_RST;
  bit         calm = 1'b0;
  int         rx_sent = 0;
  int         settings_used = 1;
  int         out_hold = 0;

  ascii_telecommand_frame_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .frame_id_o    (frame_id_o),
    .mantissa_o    (mantissa_o),
    .frac_digits_o (frac_digits_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // result side backpressure in short bursts
  always @(posedge clk_i) begin
    if (out_hold > 0) begin
      out_hold    <= out_hold - 1;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(99) < 3) begin
      out_hold    <= int'($urandom_range(5));
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) tracker.write_register(cfg_reg_e'(cfg_index_i), cfg_data_i);
      if (in_valid_i && in_ready_o) tracker.parse_byte(rx_byte_i);
      if (out_valid_o && out_ready_i) tracker.check_frame(frame_id_o, mantissa_o, frac_digits_o);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(99) < 5) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    rx_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // let every open frame come out, then give the parser a few quiet cycles
  task automatic settle();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_delimiters(input logic [7:0] s, input logic [7:0] e);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_START_BYTE;
    cfg_data_i  <= s;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CFG_STOP_BYTE;
    cfg_data_i  <= e;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_start = s;
    cur_stop  = e;
    settings_used++;
  endtask

  // kind 0 overlong, 1 extra dots, 2 misplaced sign, 3 stray byte,
  // 4 no stop, 5 plain noise, 6 well formed
  task automatic send_frame(input bit broken);
    logic [7:0] body[$];
    int         nchars;
    int         kind;
    body.delete();
    kind = broken ? int'($urandom_range(5)) : 6;
    if (kind == 5) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
      return;
    end
    nchars = (kind == 0) ? int'(MAX_CHARS_DEF) + int'($urandom_range(1, 3))
                         : int'($urandom_range(MAX_CHARS_DEF));
    if (nchars > 0 && $urandom_range(2) == 0) begin
      body.push_back($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
    end
    while (body.size() < nchars) begin
      body.push_back(($urandom_range(7) == 0) ? CHAR_NINE : CHAR_ZERO + 8'($urandom_range(9)));
    end
    if (nchars > 1 && $urandom_range(1) == 1) body[$urandom_range(nchars - 1)] = CHAR_DOT;
    case (kind)
      1: begin
        body.insert($urandom_range(body.size()), CHAR_DOT);
        body.insert($urandom_range(body.size()), CHAR_DOT);
      end
      2: body.insert((body.size() == 0) ? 0 : $urandom_range(1, body.size()), CHAR_MINUS);
      3: body.insert($urandom_range(body.size()), 8'($urandom_range(255)));
      default: ;
    endcase
    send_byte(cur_start);
    if ($urandom_range(9) == 0) send_byte(cur_start);
    send_byte(8'($urandom_range(255)));
    foreach (body[i]) send_byte(body[i]);
    if (kind != 4) send_byte(cur_stop);
  endtask

  initial begin
    #200000;
    $display("%0t: timeout with %0d frames outstanding", $time, tracker.pending());
    $display("status: fail");
    $finish;
  end

  initial begin
    int phase_start;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames with the reset delimiters
    send_text("$A999999999999#");
    send_text("$B-99999999999#");
    send_text("$C.99999999999#");
    send_text("$$D12#");
    send_text("$#5#");
    send_text("$E#");
    send_text("$F-.#");
    send_text("$F-0#");
    send_text("$G1+2#$G--1#");
    send_text("$H1.2.3#");
    send_text("$I1234567890123#");
    send_text("$J12$K34#");
    send_text("$L1x2#");
    send_text("$M+0.5#");
    send_byte(cur_start);
    send_byte(8'h00);
    send_text("7");
    send_byte(cur_stop);
    send_byte(cur_start);
    send_byte(8'hFF);
    send_byte(cur_stop);
    settle();

    // a sign inside the field is not taken as a start byte
    set_delimiters(CHAR_PLUS, STOP_BYTE_RST);
    send_text("+A+1#++B-2#");
    settle();
    // equal delimiters: the start byte wins, nothing closes
    set_delimiters(8'h40, 8'h40);
    send_text("@A1@B@C2@");
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_delimiters(START_BYTE_RST, STOP_BYTE_RST);
        1: set_delimiters(8'h00, 8'hFF);
        2: set_delimiters(8'hFF, 8'h00);
        3: set_delimiters(START_BYTE_RST, STOP_BYTE_RST);
        default: set_delimiters(8'($urandom_range(255)), 8'($urandom_range(255)));
      endcase
      calm = (p == 3);
      phase_start = rx_sent;
      while (rx_sent - phase_start < PHASE_BYTES) send_frame($urandom_range(99) < 30);
      settle();
    end
    calm = 1'b0;

    $display("covered %0d received bytes over %0d delimiter settings, %0d frames compared",
             rx_sent, settings_used, tracker.frames_checked);
    if (tracker.pending() != 0) begin
      $display("%0t: %0d expected frames never arrived", $time, tracker.pending());
    end
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
